// ===== hdl/lzw_ee_pkg.sv =====
// Package with the shared types, constants and hash function of the LZW encoder.
`default_nettype none
package lzw_ee_pkg;
    localparam int CodeBits   = 16;
    localparam int SlotBits   = 17;
    localparam int CodeSpace  = 65536;
    localparam int TableSlots = 131072;
    localparam int FifoDepth  = 4;

    localparam logic [SlotBits-1:0] HashMult  = 17'h179B1;
    localparam logic [16:0]         CodeLimit = 17'(CodeSpace);
    localparam logic [16:0]         MissLimit = 17'(CodeSpace - 1);
    localparam logic [16:0]         FirstFree = 17'd256;
    localparam logic [3:0]          ChainReset = 4'd4;

    typedef struct packed {
        logic                valid;
        logic [CodeBits-1:0] prefix;
        logic [7:0]          byte_val;
        logic [CodeBits-1:0] code;
    } t_slot;

    typedef struct packed {
        logic [CodeBits-1:0] code;
        logic                last;
    } t_result;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_READ,
        S_CHECK,
        S_FINISH
    } t_state;

    function automatic logic [SlotBits-1:0] hash_slot(logic [CodeBits-1:0] prefix,
                                                      logic [7:0] byte_val);
        logic [40:0] prod;
        prod = {17'b0, prefix, byte_val} * {24'b0, HashMult};
        return prod[SlotBits-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== hdl/lzw_ee_dict_ram.sv =====
// Single-ported dictionary slot memory with registered read data.
`default_nettype none
module lzw_ee_dict_ram
    import lzw_ee_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_we,
    input  wire logic [SlotBits-1:0] i_addr,
    input  wire t_slot               i_wdata,
    output t_slot                    o_rdata
);
    t_slot mem [TableSlots];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== hdl/lzw_ee_out_fifo.sv =====
// Small result queue between the encoder core and the output channel.
`default_nettype none
module lzw_ee_out_fifo
    import lzw_ee_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    input  wire logic    i_stall,
    output logic         o_valid,
    output t_result      o_data,
    output logic         o_room
);
    t_result     r_mem [FifoDepth];
    logic [1:0]  r_wptr;
    logic [1:0]  r_rptr;
    logic [2:0]  r_count;
    logic        pop;

    assign o_valid = (r_count != 3'd0);
    assign o_data  = r_mem[r_rptr];
    assign o_room  = (r_count <= 3'd2);
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 2'd1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 2'd1;
            end
            r_count <= r_count + {2'b0, i_push} - {2'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ===== hdl/lzw_extended_entry_encoder.sv =====
// Top level of the LZW encoder with extension chain entries.
`default_nettype none
// The encoder takes one byte per request and returns dictionary codes through a
// four-entry result queue. After reset it clears the 131072-slot dictionary
// memory, one slot per cycle, and takes the first request once that is done.
// A byte with no pending match goes straight to the closing state S_FINISH;
// otherwise each lookup passes S_HASH, then S_READ and S_CHECK for each slot
// probed in the single-ported dictionary memory, a chain insert costs a second
// such probe sequence, and S_FINISH closes the request. A request is taken while
// the encoder is idle and the queue holds at most two results.
module lzw_extended_entry_encoder
    import lzw_ee_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_input,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_out_code,
    output logic             o_last_of_run,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [3:0]  i_cfg_data
);
    t_state                r_state, n_state;
    logic [7:0]            r_byte;
    logic                  r_last;
    logic [CodeBits-1:0]   r_match;
    logic                  r_match_valid;
    logic [16:0]           r_nfc;
    logic [CodeBits-1:0]   r_chain_code;
    logic [3:0]            r_chain_count;
    logic [3:0]            r_chain_len;
    logic [SlotBits-1:0]   r_slot;
    logic [SlotBits-1:0]   r_probes;
    logic                  r_adding;
    logic [CodeBits-1:0]   r_key;

    logic                  accept;
    logic                  room;
    logic                  mem_we;
    t_slot                 mem_wdata;
    t_slot                 rdata;
    logic                  push;
    t_result               push_data;
    t_result               head;
    logic                  hit, free_slot, full, cont;
    logic                  chain_go;

    lzw_ee_dict_ram u_dict (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (r_slot),
        .i_wdata (mem_wdata),
        .o_rdata (rdata)
    );

    lzw_ee_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_data  (head),
        .o_room  (room)
    );

    assign o_out_code    = head.code;
    assign o_last_of_run = head.last;
    assign o_cfg_ready   = 1'b1;
    assign o_stall       = !((r_state == S_IDLE) && room);
    assign accept        = i_valid && !o_stall;

    assign hit       = rdata.valid && (rdata.prefix == r_key) && (rdata.byte_val == r_byte);
    assign free_slot = !rdata.valid;
    assign full      = !hit && !free_slot && (r_probes == '1);
    assign cont      = !hit && !free_slot && !full;
    assign chain_go  = (r_chain_count > 4'd1) && (r_nfc < CodeLimit);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:  if (r_slot == '1) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) n_state = r_match_valid ? S_HASH : S_FINISH;
            end
            S_HASH:   n_state = S_READ;
            S_READ:   n_state = S_CHECK;
            S_CHECK: begin
                if (cont) begin
                    n_state = S_READ;
                end else if (!r_adding && hit && chain_go) begin
                    n_state = S_HASH;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = '{valid: 1'b1, prefix: r_key, byte_val: r_byte, code: r_nfc[15:0]};
        push      = 1'b0;
        push_data = '{code: r_match, last: 1'b1};
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
            end
            S_CHECK: begin
                if (r_adding) begin
                    mem_we = hit || free_slot;
                end else if (!hit && !cont) begin
                    push      = 1'b1;
                    push_data = '{code: r_match, last: !r_last};
                    mem_we    = free_slot && (r_nfc < MissLimit);
                end
            end
            S_FINISH: push = r_last;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_slot        <= '0;
            r_match       <= '0;
            r_match_valid <= 1'b0;
            r_nfc         <= FirstFree;
            r_chain_code  <= '0;
            r_chain_count <= '0;
            r_chain_len   <= ChainReset;
            r_adding      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_chain_len <= i_cfg_data;
            end
            unique case (r_state)
                S_CLEAR: r_slot <= r_slot + 1'b1;
                S_IDLE: begin
                    if (accept) begin
                        r_byte   <= i_data_byte;
                        r_last   <= i_end_of_input;
                        r_key    <= r_match;
                        r_adding <= 1'b0;
                        if (!r_match_valid) begin
                            r_match       <= {8'b0, i_data_byte};
                            r_match_valid <= 1'b1;
                        end
                    end
                end
                S_HASH: begin
                    r_slot   <= hash_slot(r_key, r_byte);
                    r_probes <= '0;
                end
                S_CHECK: begin
                    if (cont) begin
                        r_slot   <= r_slot + 1'b1;
                        r_probes <= r_probes + 1'b1;
                    end else if (r_adding) begin
                        if (full) begin
                            r_chain_count <= '0;
                        end else begin
                            r_chain_code  <= r_nfc[15:0];
                            r_nfc         <= r_nfc + 17'd1;
                            r_chain_count <= r_chain_count - 4'd1;
                        end
                    end else if (hit) begin
                        r_match <= rdata.code;
                        if (r_chain_count > 4'd1) begin
                            if (r_nfc < CodeLimit) begin
                                r_adding <= 1'b1;
                                r_key    <= r_chain_code;
                            end else begin
                                r_chain_count <= '0;
                            end
                        end
                    end else begin
                        if (free_slot && (r_nfc < MissLimit)) begin
                            r_chain_code  <= r_nfc[15:0];
                            r_nfc         <= r_nfc + 17'd1;
                            r_chain_count <= r_chain_len;
                        end else begin
                            r_chain_count <= '0;
                        end
                        r_match <= {8'b0, r_byte};
                    end
                end
                S_FINISH: begin
                    if (r_last) begin
                        r_match_valid <= 1'b0;
                        r_chain_count <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("Request taken while the encoder is busy.");

    a_code_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nfc <= CodeLimit) && (r_nfc >= FirstFree))
        else $error("Next free code left its range.");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && (r_state == S_CHECK)) |=> (r_state == S_FINISH))
        else $error("Miss result not followed by the closing cycle.");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && (r_state == S_CHECK)) |=> (r_nfc == $past(r_nfc) + 17'd1))
        else $error("Dictionary insert did not consume a code.");
endmodule
`default_nettype wire
